// ===== hdl/isb_pkg.sv =====
// Shared constants, types and anchor position tables for the shape blend core.
// No dependencies; imported by isb_div and idw_shape_blend_core.
package isb_pkg;

  localparam int ANCHOR_COUNT = 12;
  localparam int PARAM_COUNT  = 32;
  localparam int ANC_W        = 4;
  localparam int PRM_W        = 5;
  localparam int SHAPE_DEPTH  = ANCHOR_COUNT * PARAM_COUNT;
  localparam int SHAPE_AW     = 9;
  localparam int NUM_W        = 91;   // dividend width: 61-bit weight shifted left by 30
  localparam int DVS_W        = 64;
  localparam int CNT_W        = 7;

  localparam logic [ANC_W-1:0] LAST_ANCHOR = ANC_W'(ANCHOR_COUNT - 1);
  localparam logic [PRM_W-1:0] LAST_PARAM  = PRM_W'(PARAM_COUNT - 1);

  localparam logic [CNT_W-1:0] W_STEPS    = CNT_W'(61);
  localparam logic [CNT_W-1:0] NORM_STEPS = CNT_W'(91);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_BLEND = 1'b1;

  typedef logic [11:0] hz_t;

  function automatic hz_t pos_f1(input logic [ANC_W-1:0] idx);
    hz_t v;
    case (idx)
      4'd0:    v = 12'd280;
      4'd1:    v = 12'd400;
      4'd2:    v = 12'd400;
      4'd3:    v = 12'd550;
      4'd4:    v = 12'd700;
      4'd5:    v = 12'd730;
      4'd6:    v = 12'd600;
      4'd7:    v = 12'd650;
      4'd8:    v = 12'd500;
      4'd9:    v = 12'd450;
      4'd10:   v = 12'd450;
      4'd11:   v = 12'd300;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  function automatic hz_t pos_f2(input logic [ANC_W-1:0] idx);
    hz_t v;
    case (idx)
      4'd0:    v = 12'd2250;
      4'd1:    v = 12'd2100;
      4'd2:    v = 12'd2050;
      4'd3:    v = 12'd1850;
      4'd4:    v = 12'd1750;
      4'd5:    v = 12'd1100;
      4'd6:    v = 12'd900;
      4'd7:    v = 12'd1200;
      4'd8:    v = 12'd1500;
      4'd9:    v = 12'd850;
      4'd10:   v = 12'd1050;
      4'd11:   v = 12'd750;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  function automatic hz_t abs_diff(input hz_t a, input hz_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== hdl/isb_div.sv =====
// Restoring divider, one quotient bit per cycle, dividend consumed MSB first.
// Depends on isb_pkg for widths.
module isb_div
  import isb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  input  logic [CNT_W-1:0] steps,
  output logic             done,
  output logic [DVS_W-1:0] quotient
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [NUM_W-1:0] num_r;
  logic [DVS_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic             qbit;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= dividend;
      quo_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // keep the partial remainder below the divisor
      rem_r <= qbit ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[DVS_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/idw_shape_blend_core.sv =====
// Top level of the inverse-distance (power 4) vowel shape blend core.
// Depends on isb_pkg and instantiates the shared divider isb_div.
//
//  channel   | ports                                   | transaction
//  ----------+-----------------------------------------+----------------------------------
//  command   | start, busy, in_*                       | start high while busy low
//  result    | out_strobe, out_*                       | one cycle per result, no backpressure
//  config    | cfg_valid, cfg_ready, cfg_data          | valid and ready high (ready always high)
//
// A load writes at the accepting edge and busy never rises. A blend runs a
// weight divide per enabled anchor (61 divider steps), a normalization divide
// per enabled anchor (91 divider steps), then the weighted sums over 32 parameters,
// each a multiply-accumulate pass over every anchor. The shared bit-serial
// divider paces both divides, the single table read port and multiplier the
// weighted sums.
// Reset (rst_n low, synchronous) clears control state and sets the enable mask
// to all ones; table and weight memories hold garbage until written.
// Results cannot be stalled; out_strobe is high for exactly one cycle per result.
module idw_shape_blend_core
  import isb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic [ANC_W-1:0]   in_anchor_index,
  input  logic [PRM_W-1:0]   in_param_index,
  input  logic signed [31:0] in_param_value,
  input  logic [11:0]        in_f1_hz,
  input  logic [11:0]        in_f2_hz,
  output logic               out_strobe,
  output logic [PRM_W-1:0]   out_index,
  output logic signed [31:0] out_blended_value,
  output logic               out_valid_res,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [11:0]        cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DMUL   = 4'd1;
  localparam logic [3:0] S_DADD   = 4'd2;
  localparam logic [3:0] S_DSQ    = 4'd3;
  localparam logic [3:0] S_WSTART = 4'd4;
  localparam logic [3:0] S_WDIV   = 4'd5;
  localparam logic [3:0] S_NRD    = 4'd6;
  localparam logic [3:0] S_NWAIT  = 4'd7;
  localparam logic [3:0] S_NDIV   = 4'd8;
  localparam logic [3:0] S_ARD    = 4'd9;
  localparam logic [3:0] S_AMUL   = 4'd10;
  localparam logic [3:0] S_AADD   = 4'd11;

  logic [3:0]       state_r;
  logic [11:0]      mask_r;
  logic [ANC_W-1:0] anc_r;
  logic [PRM_W-1:0] prm_r;
  logic             any_r;
  hz_t              f1_r;
  hz_t              f2_r;
  logic [23:0]      sq1_r;
  logic [23:0]      sq2_r;
  logic [24:0]      d2_r;
  logic [49:0]      d2sq_r;
  logic [63:0]      sum_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] acc_sum;

  logic             strobe_r;
  logic [PRM_W-1:0] oidx_r;
  logic [31:0]      oval_r;
  logic             ovalid_r;
  logic             olast_r;

  // Storage: shape table and per-anchor weight scratch.
  logic [31:0]         shape_mem [0:SHAPE_DEPTH-1];
  logic [63:0]         weight_mem [0:ANCHOR_COUNT-1];
  logic [31:0]         shape_rd_r;
  logic [63:0]         weight_rd_r;
  logic                shape_we;
  logic [SHAPE_AW-1:0] shape_waddr;
  logic                weight_we;

  // Divider hookup
  logic             div_start;
  logic [NUM_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [CNT_W-1:0] div_steps;
  logic             div_done;
  logic [DVS_W-1:0] div_q;

  logic             anc_en;
  hz_t              d1;
  hz_t              d2v;

  assign anc_en  = mask_r[anc_r];
  assign d1      = abs_diff(f1_r, pos_f1(anc_r));
  assign d2v     = abs_diff(f2_r, pos_f2(anc_r));
  assign acc_sum = acc_r + prod_r;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Load writes at the accepting edge; anchors past the table are dropped.
  assign shape_we    = start && !busy && (in_cmd == CMD_LOAD) && (in_anchor_index <= LAST_ANCHOR);
  assign shape_waddr = {in_anchor_index, in_param_index};
  assign weight_we   = ((state_r == S_WDIV) || (state_r == S_NDIV)) && div_done;

  always_ff @(posedge clk) begin
    if (shape_we) begin
      shape_mem[shape_waddr] <= in_param_value;
    end
    shape_rd_r <= shape_mem[{anc_r, prm_r}];
  end

  always_ff @(posedge clk) begin
    if (weight_we) begin
      weight_mem[anc_r] <= div_q;
    end
    weight_rd_r <= weight_mem[anc_r];
  end

  // Raw weight 2^60/d2^2, then normalized weight (w << 30)/sum.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b1, {(NUM_W-1){1'b0}}};
    div_divisor  = {14'd0, d2sq_r};
    div_steps    = W_STEPS;
    if (state_r == S_WSTART) begin
      div_start = 1'b1;
    end else if (state_r == S_NWAIT) begin
      div_start    = 1'b1;
      div_dividend = {weight_rd_r[60:0], 30'd0};
      div_divisor  = sum_r;
      div_steps    = NORM_STEPS;
    end
  end

  isb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      f1_r <= in_f1_hz;
      f2_r <= in_f2_hz;
    end
    sq1_r  <= d1 * d1;
    sq2_r  <= d2v * d2v;
    d2_r   <= ((25'(sq1_r) + 25'(sq2_r)) == 25'd0) ? 25'd1 : (25'(sq1_r) + 25'(sq2_r));
    d2sq_r <= d2_r * d2_r;
    // normalized weight is at most 2^30, so it fits a 32-bit signed operand
    prod_r <= anc_en ? ($signed({1'b0, weight_rd_r[30:0]}) * $signed(shape_rd_r)) : 64'sd0;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mask_r   <= 12'hFFF;
      anc_r    <= '0;
      prm_r    <= '0;
      any_r    <= 1'b0;
      sum_r    <= '0;
      acc_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start && in_cmd == CMD_BLEND) begin
            anc_r   <= '0;
            any_r   <= 1'b0;
            sum_r   <= '0;
            state_r <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (anc_en) begin
            state_r <= S_DADD;
          end else if (anc_r != LAST_ANCHOR) begin
            anc_r <= anc_r + 1'b1;
          end else if (any_r) begin
            anc_r   <= '0;
            state_r <= S_NRD;
          end else begin
            // no anchor enabled: one invalid result
            oidx_r   <= '0;
            oval_r   <= '0;
            ovalid_r <= 1'b0;
            olast_r  <= 1'b1;
            strobe_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        S_DADD:   state_r <= S_DSQ;
        S_DSQ:    state_r <= S_WSTART;
        S_WSTART: state_r <= S_WDIV;
        S_WDIV: begin
          if (div_done) begin
            sum_r <= sum_r + div_q;
            any_r <= 1'b1;
            if (anc_r != LAST_ANCHOR) begin
              anc_r   <= anc_r + 1'b1;
              state_r <= S_DMUL;
            end else begin
              anc_r   <= '0;
              state_r <= S_NRD;
            end
          end
        end
        S_NRD: begin
          if (anc_en) begin
            state_r <= S_NWAIT;
          end else if (anc_r != LAST_ANCHOR) begin
            anc_r <= anc_r + 1'b1;
          end else begin
            anc_r   <= '0;
            prm_r   <= '0;
            acc_r   <= '0;
            state_r <= S_ARD;
          end
        end
        S_NWAIT: state_r <= S_NDIV;
        S_NDIV: begin
          if (div_done) begin
            if (anc_r != LAST_ANCHOR) begin
              anc_r   <= anc_r + 1'b1;
              state_r <= S_NRD;
            end else begin
              anc_r   <= '0;
              prm_r   <= '0;
              acc_r   <= '0;
              state_r <= S_ARD;
            end
          end
        end
        S_ARD:  state_r <= S_AMUL;
        S_AMUL: state_r <= S_AADD;
        S_AADD: begin
          if (anc_r != LAST_ANCHOR) begin
            acc_r   <= acc_sum;
            anc_r   <= anc_r + 1'b1;
            state_r <= S_ARD;
          end else begin
            // arithmetic shift floors toward minus infinity
            oidx_r   <= prm_r;
            oval_r   <= acc_sum[61:30];
            ovalid_r <= 1'b1;
            olast_r  <= (prm_r == LAST_PARAM);
            strobe_r <= 1'b1;
            acc_r    <= '0;
            anc_r    <= '0;
            prm_r    <= prm_r + 1'b1;
            state_r  <= (prm_r == LAST_PARAM) ? S_IDLE : S_ARD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe        = strobe_r;
  assign out_index         = oidx_r;
  assign out_blended_value = oval_r;
  assign out_valid_res     = ovalid_r;
  assign out_last          = olast_r;

endmodule
